@@ sv/wash_cycle_sequencer_core_assert.svh @@
// Assertion macros used by the sequencer core RTL.
`ifndef WASH_CYCLE_SEQUENCER_CORE_ASSERT_SVH
`define WASH_CYCLE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/wcs_pkg.sv @@
package wcs_pkg;

   // Command codes carried in the op field.
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_PAUSE = 2'd2;
   localparam logic [1:0] OP_OFF   = 2'd3;

   // Run mode codes.
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_PAUSE = 2'd2;

   // Stage codes.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FILL1  = 4'd1;
   localparam logic [3:0] ST_HEAT   = 4'd2;
   localparam logic [3:0] ST_WASHR  = 4'd3;
   localparam logic [3:0] ST_WASHL  = 4'd4;
   localparam logic [3:0] ST_DRAIN1 = 4'd5;
   localparam logic [3:0] ST_FILL2  = 4'd6;
   localparam logic [3:0] ST_RINSER = 4'd7;
   localparam logic [3:0] ST_RINSEL = 4'd8;
   localparam logic [3:0] ST_DRAIN2 = 4'd9;

   // Display codes.
   localparam logic [2:0] DISP_IDLE   = 3'd0;
   localparam logic [2:0] DISP_FILL   = 3'd1;
   localparam logic [2:0] DISP_HEAT   = 3'd2;
   localparam logic [2:0] DISP_WASH   = 3'd3;
   localparam logic [2:0] DISP_DRAIN  = 3'd4;
   localparam logic [2:0] DISP_RINSE  = 3'd5;
   localparam logic [2:0] DISP_PAUSED = 3'd6;
   localparam logic [2:0] DISP_ERROR  = 3'd7;

   // Dial codes; any other setting keeps the current spin count.
   localparam logic [1:0] DIAL_COTTON = 2'd0;
   localparam logic [1:0] DIAL_WOOL   = 2'd1;
   localparam logic [1:0] DIAL_KEEP   = 2'd2;

   // Actuator bit positions.
   localparam int ACT_DOOR   = 0;
   localparam int ACT_VALVE  = 1;
   localparam int ACT_HEATER = 2;
   localparam int ACT_PUMP   = 3;
   localparam int ACT_HATCH  = 4;

   // Spin durations and motor duties.
   localparam logic [5:0] WASH_TICKS_COTTON = 6'd40;
   localparam logic [5:0] WASH_TICKS_WOOL   = 6'd20;
   localparam logic [7:0] SPEED_WASH        = 8'd128;
   localparam logic [7:0] SPEED_RINSE       = 8'd255;

   // Configuration register indexes and reset values.
   localparam logic [1:0]  CSR_FILL_TIMEOUT = 2'd0;
   localparam logic [1:0]  CSR_HEAT_TIMEOUT = 2'd1;
   localparam logic [1:0]  CSR_TARGET_TEMP  = 2'd2;
   localparam logic [15:0] FILL_TIMEOUT_RST = 16'd600;
   localparam logic [15:0] HEAT_TIMEOUT_RST = 16'd1200;
   localparam logic [7:0]  TARGET_TEMP_RST  = 8'd40;

   typedef struct packed {
      logic [1:0] op;
      logic       drum_full;
      logic       water_empty;
      logic [7:0] water_temperature;
      logic [1:0] dial;
   } req_type;

   typedef struct packed {
      logic [3:0]  current_stage;
      logic [2:0]  display_code;
      logic        door_lock;
      logic        water_valve;
      logic        heater;
      logic        pump;
      logic        detergent_hatch;
      logic [7:0]  motor_speed;
      logic        motor_left;
      logic        fault;
      logic        error_led;
      logic [15:0] elapsed_ticks;
   } rsp_type;

   typedef struct packed {
      logic [15:0] fill_timeout;
      logic [15:0] heat_timeout;
      logic [7:0]  target_temperature;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  run_mode;
      logic        in_process;
      logic [3:0]  stage;
      logic [15:0] stage_time;
      logic [5:0]  wash_ticks;
      logic        error_latched;
      logic        blink_phase;
      logic [4:0]  actuators;
      logic [7:0]  motor_speed;
      logic        motor_left;
      logic [2:0]  display;
   } seq_state_type;

endpackage

@@ sv/wcs_step.sv @@
module wcs_step (
   input  wcs_pkg::cfg_type       cfg,
   input  wcs_pkg::seq_state_type cur,
   input  wcs_pkg::req_type       req,
   output wcs_pkg::seq_state_type nxt,
   output wcs_pkg::rsp_type       rsp
);

   logic [15:0] tick_next;
   logic [7:0]  spin_speed;
   logic        spin_left;
   logic [2:0]  spin_disp;
   logic        spin_hatch;
   logic [3:0]  spin_after;
   logic        led;

   // Stage timer advanced by one tick, wrapping at 16 bits.
   assign tick_next = cur.stage_time + 16'd1;

   // Per-stage settings of the four spin stages.
   always_comb begin
      spin_speed = wcs_pkg::SPEED_WASH;
      spin_left  = 1'b0;
      spin_disp  = wcs_pkg::DISP_WASH;
      spin_hatch = 1'b0;
      spin_after = wcs_pkg::ST_WASHL;
      case (cur.stage)
         wcs_pkg::ST_WASHR: begin
            spin_hatch = 1'b1;
         end
         wcs_pkg::ST_WASHL: begin
            spin_left  = 1'b1;
            spin_after = wcs_pkg::ST_DRAIN1;
         end
         wcs_pkg::ST_RINSER: begin
            spin_speed = wcs_pkg::SPEED_RINSE;
            spin_disp  = wcs_pkg::DISP_RINSE;
            spin_after = wcs_pkg::ST_RINSEL;
         end
         wcs_pkg::ST_RINSEL: begin
            spin_speed = wcs_pkg::SPEED_RINSE;
            spin_left  = 1'b1;
            spin_disp  = wcs_pkg::DISP_RINSE;
            spin_after = wcs_pkg::ST_DRAIN2;
         end
         default: begin
         end
      endcase
   end

   // One tick of the cycle: command, stage step, off handling, fault override.
   always_comb begin
      nxt = cur;
      led = 1'b0;

      unique case (req.op)
         wcs_pkg::OP_START: nxt.run_mode = wcs_pkg::MODE_START;
         wcs_pkg::OP_PAUSE: nxt.run_mode = wcs_pkg::MODE_PAUSE;
         wcs_pkg::OP_OFF:   nxt.run_mode = wcs_pkg::MODE_OFF;
         default: begin
         end
      endcase

      if (!cur.error_latched) begin
         if (nxt.run_mode == wcs_pkg::MODE_START || cur.in_process) begin
            unique case (cur.stage) inside
               wcs_pkg::ST_IDLE: begin
                  nxt.stage      = wcs_pkg::ST_FILL1;
                  nxt.stage_time = '0;
               end
               wcs_pkg::ST_FILL1, wcs_pkg::ST_FILL2: begin
                  nxt.stage_time = tick_next;
                  if (tick_next >= cfg.fill_timeout) begin
                     nxt.error_latched = 1'b1;
                  end
                  nxt.display    = wcs_pkg::DISP_FILL;
                  nxt.in_process = 1'b1;
                  if (cur.stage == wcs_pkg::ST_FILL1) begin
                     nxt.actuators[wcs_pkg::ACT_DOOR] = 1'b1;
                  end
                  nxt.actuators[wcs_pkg::ACT_VALVE] = 1'b1;
                  if (req.drum_full) begin
                     nxt.actuators[wcs_pkg::ACT_VALVE] = 1'b0;
                     nxt.stage      = (cur.stage == wcs_pkg::ST_FILL1) ?
                                      wcs_pkg::ST_HEAT : wcs_pkg::ST_RINSER;
                     nxt.in_process = 1'b0;
                     nxt.stage_time = '0;
                  end
               end
               wcs_pkg::ST_HEAT: begin
                  nxt.stage_time = tick_next;
                  if (tick_next >= cfg.heat_timeout) begin
                     nxt.error_latched = 1'b1;
                  end
                  nxt.in_process = 1'b1;
                  nxt.display    = wcs_pkg::DISP_HEAT;
                  nxt.actuators[wcs_pkg::ACT_HEATER] = 1'b1;
                  if (req.water_temperature >= cfg.target_temperature) begin
                     nxt.actuators[wcs_pkg::ACT_HEATER] = 1'b0;
                     nxt.stage      = wcs_pkg::ST_WASHR;
                     nxt.in_process = 1'b0;
                     nxt.stage_time = '0;
                  end
               end
               wcs_pkg::ST_WASHR, wcs_pkg::ST_WASHL,
               wcs_pkg::ST_RINSER, wcs_pkg::ST_RINSEL: begin
                  nxt.stage_time = tick_next;
                  if (tick_next < {10'd0, cur.wash_ticks}) begin
                     nxt.in_process  = 1'b1;
                     nxt.display     = spin_disp;
                     nxt.motor_speed = spin_speed;
                     nxt.motor_left  = spin_left;
                     if (spin_hatch) begin
                        nxt.actuators[wcs_pkg::ACT_HATCH] = 1'b1;
                     end
                  end else begin
                     nxt.motor_speed = '0;
                     nxt.motor_left  = 1'b0;
                     if (spin_hatch) begin
                        nxt.actuators[wcs_pkg::ACT_HATCH] = 1'b0;
                     end
                     nxt.stage      = spin_after;
                     nxt.in_process = 1'b0;
                     nxt.stage_time = '0;
                  end
               end
               wcs_pkg::ST_DRAIN1, wcs_pkg::ST_DRAIN2: begin
                  nxt.stage_time = tick_next;
                  if (tick_next >= cfg.fill_timeout) begin
                     nxt.error_latched = 1'b1;
                  end
                  nxt.in_process = 1'b1;
                  nxt.display    = wcs_pkg::DISP_DRAIN;
                  nxt.actuators[wcs_pkg::ACT_PUMP] = 1'b1;
                  if (req.water_empty) begin
                     nxt.actuators[wcs_pkg::ACT_PUMP] = 1'b0;
                     nxt.in_process = 1'b0;
                     nxt.stage_time = '0;
                     if (cur.stage == wcs_pkg::ST_DRAIN1) begin
                        nxt.stage = wcs_pkg::ST_FILL2;
                     end else begin
                        nxt.stage    = wcs_pkg::ST_IDLE;
                        nxt.run_mode = wcs_pkg::MODE_OFF;
                     end
                  end
               end
               default: begin
               end
            endcase
         end else if (nxt.run_mode == wcs_pkg::MODE_PAUSE) begin
            nxt.display = wcs_pkg::DISP_PAUSED;
         end
      end

      // Off mode releases the door and samples the dial.
      if (nxt.run_mode == wcs_pkg::MODE_OFF) begin
         nxt.display = wcs_pkg::DISP_IDLE;
         nxt.actuators[wcs_pkg::ACT_DOOR] = 1'b0;
         if (req.dial == wcs_pkg::DIAL_COTTON) begin
            nxt.wash_ticks = wcs_pkg::WASH_TICKS_COTTON;
         end else if (req.dial == wcs_pkg::DIAL_WOOL) begin
            nxt.wash_ticks = wcs_pkg::WASH_TICKS_WOOL;
         end
      end

      // A latched fault forces everything off and blinks the LED.
      if (nxt.error_latched) begin
         nxt.display     = wcs_pkg::DISP_ERROR;
         led             = cur.blink_phase;
         nxt.actuators   = '0;
         nxt.motor_speed = '0;
         nxt.motor_left  = 1'b0;
         nxt.blink_phase = ~cur.blink_phase;
      end
   end

   // Result word built from the updated state.
   always_comb begin
      rsp.current_stage   = nxt.stage;
      rsp.display_code    = nxt.display;
      rsp.door_lock       = nxt.actuators[wcs_pkg::ACT_DOOR];
      rsp.water_valve     = nxt.actuators[wcs_pkg::ACT_VALVE];
      rsp.heater          = nxt.actuators[wcs_pkg::ACT_HEATER];
      rsp.pump            = nxt.actuators[wcs_pkg::ACT_PUMP];
      rsp.detergent_hatch = nxt.actuators[wcs_pkg::ACT_HATCH];
      rsp.motor_speed     = nxt.motor_speed;
      rsp.motor_left      = nxt.motor_left;
      rsp.fault           = nxt.error_latched;
      rsp.error_led       = led;
      rsp.elapsed_ticks   = nxt.stage_time;
   end

endmodule

@@ sv/wash_cycle_sequencer_core.sv @@
// A word accepted on req is held in the input register, stepped through the state
// update, and presented on rsp from the result register.
// Throughput: one word per cycle while rsp_stall does not hold the result register;
// the combinational state update between the input and result registers sets that figure.
// Reset: synchronous, active high; returns the cycle to idle with all actuators
// off, clears the fault, and loads the default timeouts and target temperature.
`include "wash_cycle_sequencer_core_assert.svh"

module wash_cycle_sequencer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wcs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   logic                   in_valid_ff;
   wcs_pkg::req_type       in_data_ff;
   logic                   out_valid_ff;
   wcs_pkg::rsp_type       out_data_ff;
   wcs_pkg::seq_state_type state_ff;
   wcs_pkg::seq_state_type state_in;
   wcs_pkg::rsp_type       rsp_in;
   wcs_pkg::cfg_type       cfg_ff;
   logic                   step_go;

   // The held word moves on when the result register is free or being drained.
   assign step_go   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_go;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   wcs_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (in_data_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_go) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         out_data_ff <= rsp_in;
      end
   end

   // Sequencer state, updated once per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.run_mode      <= wcs_pkg::MODE_OFF;
         state_ff.in_process    <= 1'b0;
         state_ff.stage         <= wcs_pkg::ST_IDLE;
         state_ff.stage_time    <= '0;
         state_ff.wash_ticks    <= '0;
         state_ff.error_latched <= 1'b0;
         state_ff.blink_phase   <= 1'b0;
         state_ff.actuators     <= '0;
         state_ff.motor_speed   <= '0;
         state_ff.motor_left    <= 1'b0;
         state_ff.display       <= wcs_pkg::DISP_IDLE;
      end else if (step_go) begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_timeout       <= wcs_pkg::FILL_TIMEOUT_RST;
         cfg_ff.heat_timeout       <= wcs_pkg::HEAT_TIMEOUT_RST;
         cfg_ff.target_temperature <= wcs_pkg::TARGET_TEMP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wcs_pkg::CSR_FILL_TIMEOUT: cfg_ff.fill_timeout       <= csr_data;
            wcs_pkg::CSR_HEAT_TIMEOUT: cfg_ff.heat_timeout       <= csr_data;
            wcs_pkg::CSR_TARGET_TEMP:  cfg_ff.target_temperature <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // A latched fault survives until reset.
   `WCS_ASSERT_NEXT(a_fault_sticky, clock, reset, state_ff.error_latched,
                    state_ff.error_latched, "fault cleared without reset")

   // Stage codes above the final drain are never entered.
   `WCS_ASSERT_NOW(a_stage_range, clock, reset, 1'b1,
                   state_ff.stage <= wcs_pkg::ST_DRAIN2, "stage code out of range")

   // A faulted result never drives an actuator or the motor.
   `WCS_ASSERT_NOW(a_fault_outputs_off, clock, reset, rsp_valid && rsp_data.fault,
                   !rsp_data.door_lock && !rsp_data.water_valve && !rsp_data.heater &&
                   !rsp_data.pump && !rsp_data.detergent_hatch &&
                   rsp_data.motor_speed == 8'd0, "actuator on while faulted")

   // Every state update leaves a result word behind.
   `WCS_ASSERT_NEXT(a_step_fills_output, clock, reset, step_go, out_valid_ff,
                    "stepped word missing from result register")

endmodule

@@ tb/wash_cycle_checker.sv @@
module wash_cycle_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  wcs_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  wcs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data,
   output int               mismatch_count,
   output int               words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import wcs_pkg::*;

   // Shadow copy of the sequencer state and of its settings.
   seq_state_type machine;
   cfg_type       limits;

   // Predicted result words, oldest first.
   rsp_type       predicted_words[$];

   // Leaves the current stage and restarts its tick count.
   function automatic void enter_stage(input logic [3:0] next);
      machine.stage      = next;
      machine.in_process = 1'b0;
      machine.stage_time = '0;
   endfunction

   // Counts one tick of a timed stage and latches the fault at the limit.
   function automatic void count_against(input logic [15:0] limit);
      machine.stage_time = machine.stage_time + 16'd1;
      if (machine.stage_time >= limit) begin
         machine.error_latched = 1'b1;
      end
   endfunction

   // One tick of a wash or rinse stage; it ends once the spin count is reached.
   function automatic void run_spin(input logic [7:0] speed, input logic left,
                                    input logic [2:0] disp, input logic hatch,
                                    input logic [3:0] after);
      machine.stage_time = machine.stage_time + 16'd1;
      if (machine.stage_time < {10'd0, machine.wash_ticks}) begin
         machine.in_process  = 1'b1;
         machine.display     = disp;
         machine.motor_speed = speed;
         machine.motor_left  = left;
         if (hatch) begin
            machine.actuators[ACT_HATCH] = 1'b1;
         end
      end else begin
         machine.motor_speed = '0;
         machine.motor_left  = 1'b0;
         if (hatch) begin
            machine.actuators[ACT_HATCH] = 1'b0;
         end
         enter_stage(after);
      end
   endfunction

   // Applies one tick to the shadow state and returns the word it should produce.
   function automatic rsp_type step_cycle(input req_type w);
      rsp_type r;
      logic    led;
      led = 1'b0;
      case (w.op)
         OP_START: machine.run_mode = MODE_START;
         OP_PAUSE: machine.run_mode = MODE_PAUSE;
         OP_OFF:   machine.run_mode = MODE_OFF;
         default: ;
      endcase

      // Stage stepping, frozen once a fault has latched.
      if (!machine.error_latched) begin
         if (machine.run_mode == MODE_START || machine.in_process) begin
            case (machine.stage)
               ST_IDLE: begin
                  machine.stage      = ST_FILL1;
                  machine.stage_time = '0;
               end
               ST_FILL1, ST_FILL2: begin
                  count_against(limits.fill_timeout);
                  machine.display    = DISP_FILL;
                  machine.in_process = 1'b1;
                  if (machine.stage == ST_FILL1) begin
                     machine.actuators[ACT_DOOR] = 1'b1;
                  end
                  machine.actuators[ACT_VALVE] = !w.drum_full;
                  if (w.drum_full) begin
                     enter_stage((machine.stage == ST_FILL1) ? ST_HEAT : ST_RINSER);
                  end
               end
               ST_HEAT: begin
                  count_against(limits.heat_timeout);
                  machine.in_process = 1'b1;
                  machine.display    = DISP_HEAT;
                  machine.actuators[ACT_HEATER] =
                     (w.water_temperature < limits.target_temperature);
                  if (w.water_temperature >= limits.target_temperature) begin
                     enter_stage(ST_WASHR);
                  end
               end
               ST_WASHR: run_spin(SPEED_WASH, 1'b0, DISP_WASH, 1'b1, ST_WASHL);
               ST_WASHL: run_spin(SPEED_WASH, 1'b1, DISP_WASH, 1'b0, ST_DRAIN1);
               ST_RINSER: run_spin(SPEED_RINSE, 1'b0, DISP_RINSE, 1'b0, ST_RINSEL);
               ST_RINSEL: run_spin(SPEED_RINSE, 1'b1, DISP_RINSE, 1'b0, ST_DRAIN2);
               ST_DRAIN1, ST_DRAIN2: begin
                  count_against(limits.fill_timeout);
                  machine.in_process = 1'b1;
                  machine.display    = DISP_DRAIN;
                  machine.actuators[ACT_PUMP] = !w.water_empty;
                  if (w.water_empty) begin
                     if (machine.stage == ST_DRAIN1) begin
                        enter_stage(ST_FILL2);
                     end else begin
                        enter_stage(ST_IDLE);
                        machine.run_mode = MODE_OFF;
                     end
                  end
               end
               default: ;
            endcase
         end else if (machine.run_mode == MODE_PAUSE) begin
            machine.display = DISP_PAUSED;
         end
      end

      // While off, the door unlocks and the dial sets the spin count.
      if (machine.run_mode == MODE_OFF) begin
         machine.display = DISP_IDLE;
         machine.actuators[ACT_DOOR] = 1'b0;
         if (w.dial == DIAL_COTTON) begin
            machine.wash_ticks = WASH_TICKS_COTTON;
         end else if (w.dial == DIAL_WOOL) begin
            machine.wash_ticks = WASH_TICKS_WOOL;
         end
      end

      // A latched fault forces everything off and blinks the LED.
      if (machine.error_latched) begin
         machine.display     = DISP_ERROR;
         led                 = machine.blink_phase;
         machine.actuators   = '0;
         machine.motor_speed = '0;
         machine.motor_left  = 1'b0;
         machine.blink_phase = !machine.blink_phase;
      end

      r.current_stage   = machine.stage;
      r.display_code    = machine.display;
      r.door_lock       = machine.actuators[ACT_DOOR];
      r.water_valve     = machine.actuators[ACT_VALVE];
      r.heater          = machine.actuators[ACT_HEATER];
      r.pump            = machine.actuators[ACT_PUMP];
      r.detergent_hatch = machine.actuators[ACT_HATCH];
      r.motor_speed     = machine.motor_speed;
      r.motor_left      = machine.motor_left;
      r.fault           = machine.error_latched;
      r.error_led       = led;
      r.elapsed_ticks   = machine.stage_time;
      return r;
   endfunction

   // Reports one field that differs from its prediction.
   function automatic void check_field(input string label, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         machine          = '0;
         machine.run_mode = MODE_OFF;
         machine.stage    = ST_IDLE;
         machine.display  = DISP_IDLE;
         limits.fill_timeout       = FILL_TIMEOUT_RST;
         limits.heat_timeout       = HEAT_TIMEOUT_RST;
         limits.target_temperature = TARGET_TEMP_RST;
         predicted_words.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FILL_TIMEOUT: limits.fill_timeout       = csr_data;
               CSR_HEAT_TIMEOUT: limits.heat_timeout       = csr_data;
               CSR_TARGET_TEMP:  limits.target_temperature = csr_data[7:0];
               default: ;
            endcase
         end

         // Compare a delivered result word with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
               $display("%0t ns: result word with nothing expected, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = predicted_words.pop_front();
               check_field("current_stage", 16'(want.current_stage),
                           16'(rsp_data.current_stage));
               check_field("display_code", 16'(want.display_code),
                           16'(rsp_data.display_code));
               check_field("door_lock", 16'(want.door_lock), 16'(rsp_data.door_lock));
               check_field("water_valve", 16'(want.water_valve),
                           16'(rsp_data.water_valve));
               check_field("heater", 16'(want.heater), 16'(rsp_data.heater));
               check_field("pump", 16'(want.pump), 16'(rsp_data.pump));
               check_field("detergent_hatch", 16'(want.detergent_hatch),
                           16'(rsp_data.detergent_hatch));
               check_field("motor_speed", 16'(want.motor_speed),
                           16'(rsp_data.motor_speed));
               check_field("motor_left", 16'(want.motor_left), 16'(rsp_data.motor_left));
               check_field("fault", 16'(want.fault), 16'(rsp_data.fault));
               check_field("error_led", 16'(want.error_led), 16'(rsp_data.error_led));
               check_field("elapsed_ticks", want.elapsed_ticks, rsp_data.elapsed_ticks);
            end
         end

         if (req_valid && !req_stall) begin
            predicted_words.push_back(step_cycle(req_data));
         end
      end
      words_pending <= predicted_words.size();
   end

endmodule

@@ tb/wash_cycle_sequencer_core_test.sv @@
module wash_cycle_sequencer_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wcs_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 400;
   localparam int SENDER      = 0;
   localparam int RECEIVER    = 1;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index   = CSR_FILL_TIMEOUT;
   logic [15:0]      csr_data    = '0;
   int               mismatch_count;
   int               words_pending;
   logic             hold_off_due = 1'b0;
   int               cycle_count  = 0;

   // Per side: words left in the current stretch, and whether it runs without gaps.
   int               stretch_left [2] = '{0, 0};
   bit               quiet_run    [2] = '{0, 0};

   always #10ns clock = ~clock;

   wash_cycle_sequencer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   wash_cycle_checker cycle_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Gap before the next word; each stretch has either random gaps or none, drawn at random.
   function automatic int draw_wait(input int side);
      if (stretch_left[side] == 0) begin
         stretch_left[side] = $urandom_range(1, 60);
         quiet_run[side]    = ($urandom_range(0, 2) == 0);
      end
      stretch_left[side]--;
      return quiet_run[side] ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic req_type tick_word(input logic [1:0] op, input logic full,
                                         input logic empty, input logic [7:0] temp,
                                         input logic [1:0] dial);
      req_type w;
      w.op                = op;
      w.drum_full         = full;
      w.water_empty       = empty;
      w.water_temperature = temp;
      w.dial              = dial;
      return w;
   endfunction

   // Mostly plain ticks so cycles run through; commands and sensors at random.
   function automatic req_type random_tick();
      int         pick;
      logic [1:0] op;
      logic [7:0] temp;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         op = OP_START;
      end else if (pick < 8) begin
         op = OP_PAUSE;
      end else if (pick < 10) begin
         op = OP_OFF;
      end else begin
         op = OP_NONE;
      end
      pick = $urandom_range(0, 3);
      temp = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd0 : 8'($urandom_range(0, 255));
      return tick_word(op, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, temp,
                       2'($urandom_range(0, 2)));
   endfunction

   // Offers one word after a random gap and returns at the edge that takes it.
   task automatic send_tick(input req_type w);
      int gap;
      gap = draw_wait(SENDER);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock iff !req_stall);
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock iff words_pending == 0);
   endtask

   task automatic load_settings(input logic [15:0] fill_ticks, input logic [15:0] heat_ticks,
                                input logic [7:0] target);
      csr_valid <= 1'b1;
      csr_index <= CSR_FILL_TIMEOUT;
      csr_data  <= fill_ticks;
      @(posedge clock iff csr_ready);
      csr_index <= CSR_HEAT_TIMEOUT;
      csr_data  <= heat_ticks;
      @(posedge clock iff csr_ready);
      // Upper bits are noise that the register must drop.
      csr_index <= CSR_TARGET_TEMP;
      csr_data  <= {8'($urandom), target};
      @(posedge clock iff csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Result side: random stalls per word, plus one long hold-off on request.
   initial begin : result_side
      int wait_len;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off_due) begin
            hold_off_due <= 1'b0;
            rsp_stall    <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            wait_len = draw_wait(RECEIVER);
            if (wait_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_len) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
      end
   end

   // Stimulus, phase by phase.
   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A short cycle before any dial reading, so spins end after one tick.
      send_tick(tick_word(OP_START, 1'b0, 1'b0, 8'd0, DIAL_COTTON));
      send_tick(tick_word(OP_NONE, 1'b1, 1'b1, 8'd255, DIAL_KEEP));
      send_tick(tick_word(OP_NONE, 1'b0, 1'b0, 8'd39, DIAL_COTTON));
      send_tick(tick_word(OP_NONE, 1'b0, 1'b0, 8'd40, DIAL_COTTON));
      send_tick(tick_word(OP_NONE, 1'b0, 1'b0, 8'd0, DIAL_COTTON));
      send_tick(tick_word(OP_NONE, 1'b0, 1'b0, 8'd0, DIAL_COTTON));
      send_tick(tick_word(OP_NONE, 1'b0, 1'b0, 8'd0, DIAL_COTTON));
      // Pause during a drain lets the drain finish, then holds.
      send_tick(tick_word(OP_PAUSE, 1'b0, 1'b1, 8'd0, DIAL_COTTON));
      send_tick(tick_word(OP_NONE, 1'b1, 1'b1, 8'd255, DIAL_COTTON));
      // Off between stages loads the wool count.
      send_tick(tick_word(OP_OFF, 1'b0, 1'b0, 8'd0, DIAL_WOOL));
      send_tick(tick_word(OP_START, 1'b1, 1'b0, 8'd0, DIAL_COTTON));
      send_tick(tick_word(OP_NONE, 1'b0, 1'b0, 8'd0, DIAL_COTTON));
      // Off in the middle of a rinse: the stage runs on, the count reloads.
      send_tick(tick_word(OP_OFF, 1'b0, 1'b0, 8'd0, DIAL_COTTON));
      send_tick(tick_word(OP_START, 1'b0, 1'b1, 8'd128, DIAL_KEEP));
      drain_results();

      // Reset settings, with the result side holding off so the block backs up.
      hold_off_due <= 1'b1;
      repeat (400) send_tick(random_tick());
      drain_results();

      // Longest timeouts and the hottest target.
      load_settings(16'hFFFF, 16'hFFFF, 8'd255);
      repeat (400) send_tick(random_tick());
      drain_results();

      // Coldest target: heating ends at once.
      load_settings(16'd1000, 16'd2000, 8'd0);
      repeat (400) send_tick(random_tick());
      drain_results();

      // Assorted moderate settings.
      repeat (4) begin
         load_settings(16'($urandom_range(60, 3000)), 16'($urandom_range(60, 3000)),
                       8'($urandom_range(0, 255)));
         repeat (120) send_tick(random_tick());
         drain_results();
      end

      // Shortest timeouts: the first timed stage faults while it also completes,
      // and later commands are ignored while the LED blinks.
      load_settings(16'd1, 16'd1, 8'd0);
      repeat (150) send_tick(tick_word(OP_START, 1'b1, 1'b1, 8'd255,
                                       2'($urandom_range(0, 2))));
      repeat (60) send_tick(random_tick());
      drain_results();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
